// ----- sv/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants for the comparator sequence enumerator: field widths,
// operation codes, configuration register indexes and reset settings.
// ----------------------------------------------------------------------------
package cse_pkg;

    // Fixed field widths of the item and configuration ports.
    localparam int FUNC_W    = 2;
    localparam int FIELD_W   = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Default sizing of the sequence store.
    localparam int DEF_MAX_WIRES  = 16;
    localparam int DEF_MAX_LENGTH = 16;

    // Operation codes carried by the func field.
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIRE_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NETWORK_LENGTH = 1'd1;

    // Register values after reset.
    localparam int RESET_WIRES  = 4;
    localparam int RESET_LENGTH = 4;

    // Above this wire count a refill after a (0,1) pair starts at (0,2).
    localparam int SMALL_WIRE_LIMIT = 3;

endpackage

// ----- sv/cse_ram.sv -----
// ----------------------------------------------------------------------------
// cse_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/comparator_sequence_enumerator_top.sv -----
// ----------------------------------------------------------------------------
// comparator_sequence_enumerator_top
// Steps through candidate comparator networks held as a sequence of wire
// pairs, and emits the whole sequence after every restart or advance.
// ----------------------------------------------------------------------------
// The block holds one comparator network as a sequence of wire pairs in a
// small RAM and works on one item at a time; o_stall stays high from the
// acceptance of a restart or advance until its last result item has been
// taken. A load item is written into the store as it is accepted, leaves
// the block idle and gives no result. A restart refills the sequence and
// then emits it. An advance first ripples the increment through the pairs
// (a read step and a write step per pair that carries), refills the pairs
// after the start position, scans for two equal neighboring pairs if more
// networks remain (a read step and a compare step per pair, starting over
// at the carry step whenever a match is found), and then emits. Emission
// reads, loads and then holds each pair until the receiver takes it. The
// single RAM read port is walked one pair at a time. After reset the block
// writes the initial pattern and clears the rest of the store, one entry
// per cycle, and accepts no item during that pass;
// configuration writes are taken at any time and are always ready.
// Configuration must only change while the block is idle.
// ----------------------------------------------------------------------------
module comparator_sequence_enumerator_top #(
    parameter int MAX_WIRES  = cse_pkg::DEF_MAX_WIRES,
    parameter int MAX_LENGTH = cse_pkg::DEF_MAX_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cse_pkg::CFG_W-1:0]     i_cfg_data,
    // Input item channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cse_pkg::FUNC_W-1:0]    i_func,
    input  logic [cse_pkg::FIELD_W-1:0]   i_load_position,
    input  logic [cse_pkg::FIELD_W-1:0]   i_load_first,
    input  logic [cse_pkg::FIELD_W-1:0]   i_load_second,
    // Result item channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cse_pkg::FIELD_W-1:0]   o_position,
    output logic [cse_pkg::FIELD_W-1:0]   o_first_wire,
    output logic [cse_pkg::FIELD_W-1:0]   o_second_wire,
    output logic                          o_more_available,
    output logic                          o_last_pair
);

    import cse_pkg::*;

    // Stored wire index width, arithmetic width (one extra bit so that an
    // incremented index can reach the wire count), RAM index width and the
    // width of a position counter that can also hold the length itself.
    localparam int PW  = ($clog2(MAX_WIRES) > FIELD_W) ? $clog2(MAX_WIRES) : FIELD_W;
    localparam int AW  = PW + 1;
    localparam int IW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW  = $clog2(MAX_LENGTH + 1);
    localparam int CLW = (LW > CFG_W) ? LW : CFG_W;

    // The reset pattern is built for the reset configuration, clamped to the
    // same maximums as any configured value.
    localparam int INIT_WIRES  = (RESET_WIRES < MAX_WIRES) ? RESET_WIRES : MAX_WIRES;
    localparam int INIT_LENGTH = (RESET_LENGTH < MAX_LENGTH) ? RESET_LENGTH : MAX_LENGTH;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CARRY_RD  = 4'd1;
    localparam logic [3:0] S_CARRY_WR  = 4'd2;
    localparam logic [3:0] S_REFILL    = 4'd3;
    localparam logic [3:0] S_ZERO      = 4'd4;
    localparam logic [3:0] S_SCAN_RD   = 4'd5;
    localparam logic [3:0] S_SCAN_CMP  = 4'd6;
    localparam logic [3:0] S_EMIT_RD   = 4'd7;
    localparam logic [3:0] S_EMIT_LD   = 4'd8;
    localparam logic [3:0] S_EMIT_HOLD = 4'd9;

    typedef struct packed {
        logic [PW-1:0] low;
        logic [PW-1:0] high;
    } t_pair;

    // Control state.
    logic [3:0]       r_state, n_state;
    logic [LW-1:0]    r_pos, n_pos;
    logic [LW-1:0]    r_t, n_t;
    logic [AW-1:0]    r_a, n_a;
    logic [AW-1:0]    r_b, n_b;
    logic             r_has_more, n_has_more;
    logic             r_scan, n_scan;
    logic             r_init, n_init;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_wire_count;
    logic [CFG_W-1:0] r_network_length;

    // Datapath registers.
    t_pair r_first, n_first;
    t_pair r_prev, n_prev;
    logic [FIELD_W-1:0] r_out_pos, r_out_first, r_out_second;
    logic               r_out_more, r_out_last;

    // RAM port signals.
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_pair         ram_wdata;
    t_pair         rd_pair;

    // Effective configuration and shared unit results.
    logic [AW-1:0] wires_eff;
    logic [AW-1:0] wires_use;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] len_use;
    t_pair         bump_pair;
    logic          bump_wrap;
    t_pair         fill_pair;
    logic [AW-1:0] fill_b_next;
    logic          in_accept;
    logic          out_accept;
    logic          len_last;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;

    cse_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (MAX_LENGTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos[IW-1:0]),
        .o_rdata (rd_pair)
    );

    // Wire count and length saturate into their meaningful ranges. During
    // the reset pass the reset configuration is used regardless of writes.
    always_comb begin
        logic [AW-1:0]  wc;
        logic [CLW-1:0] nl;
        wc = AW'(r_wire_count);
        nl = CLW'(r_network_length);
        if (wc < AW'(2)) begin
            wires_eff = AW'(2);
        end else if (wc > AW'(MAX_WIRES)) begin
            wires_eff = AW'(MAX_WIRES);
        end else begin
            wires_eff = wc;
        end
        if (nl == '0) begin
            len_eff = LW'(1);
        end else if (nl > CLW'(MAX_LENGTH)) begin
            len_eff = LW'(MAX_LENGTH);
        end else begin
            len_eff = LW'(nl);
        end
        wires_use = r_init ? AW'(INIT_WIRES) : wires_eff;
        len_use   = r_init ? LW'(INIT_LENGTH) : len_eff;
        len_last  = (r_pos == len_eff - LW'(1));
    end

    // Increment unit: steps the pair just read by one, wrapping to (0,1).
    always_comb begin
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        a = AW'(rd_pair.low);
        b = AW'(rd_pair.high) + AW'(1);
        bump_wrap = 1'b0;
        if (b >= wires_use) begin
            a = a + AW'(1);
            b = a + AW'(1);
        end
        if (b >= wires_use) begin
            a = AW'(0);
            b = AW'(1);
            bump_wrap = 1'b1;
        end
        bump_pair.low  = PW'(a);
        bump_pair.high = PW'(b);
    end

    // Refill unit: produces the next ascending pair from the running (a,b).
    always_comb begin
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        a = r_a;
        b = r_b;
        if (b == wires_use) begin
            a = a + AW'(1);
            b = a + AW'(1);
        end
        if (b >= wires_use) begin
            a = AW'(0);
            b = AW'(1);
        end
        fill_pair.low  = PW'(a);
        fill_pair.high = PW'(b);
        fill_b_next    = b + AW'(1);
    end

    // Sequencer.
    always_comb begin
        t_pair start_pair;
        n_state     = r_state;
        n_pos       = r_pos;
        n_t         = r_t;
        n_a         = r_a;
        n_b         = r_b;
        n_has_more  = r_has_more;
        n_scan      = r_scan;
        n_init      = r_init;
        n_out_valid = r_out_valid;
        n_first     = r_first;
        n_prev      = r_prev;
        ram_we      = 1'b0;
        ram_waddr   = r_pos[IW-1:0];
        ram_wdata   = '0;
        start_pair  = (r_pos == r_t) ? bump_pair : r_first;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_func)
                        FUNC_RESTART: begin
                            n_has_more = 1'b1;
                            n_scan     = 1'b0;
                            n_pos      = '0;
                            n_a        = AW'(0);
                            n_b        = AW'(1);
                            n_state    = S_REFILL;
                        end
                        FUNC_ADVANCE: begin
                            n_scan  = 1'b1;
                            n_t     = len_eff - LW'(1);
                            n_pos   = len_eff - LW'(1);
                            n_state = S_CARRY_RD;
                        end
                        FUNC_LOAD: begin
                            n_has_more = 1'b1;
                            if (32'(i_load_position) < 32'(MAX_LENGTH)) begin
                                ram_we         = 1'b1;
                                ram_waddr      = IW'(i_load_position);
                                ram_wdata.low  = PW'(i_load_first);
                                ram_wdata.high = PW'(i_load_second);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CARRY_RD: begin
                n_state = S_CARRY_WR;
            end
            S_CARRY_WR: begin
                ram_we    = 1'b1;
                ram_wdata = bump_pair;
                if (r_pos == r_t) begin
                    n_first = bump_pair;
                end
                if (bump_wrap && r_pos != '0) begin
                    n_pos   = r_pos - LW'(1);
                    n_state = S_CARRY_RD;
                end else begin
                    if (bump_wrap) begin
                        n_has_more = 1'b0;
                    end
                    // The refill after a (0,1) pair skips (0,1) itself on
                    // networks wider than the small limit.
                    n_pos = r_t + LW'(1);
                    n_a   = AW'(0);
                    if (start_pair.low == PW'(0) && start_pair.high == PW'(1)
                            && wires_use > AW'(SMALL_WIRE_LIMIT)) begin
                        n_b = AW'(2);
                    end else begin
                        n_b = AW'(1);
                    end
                    n_state = S_REFILL;
                end
            end
            S_REFILL: begin
                if (r_pos < len_use) begin
                    ram_we    = 1'b1;
                    ram_wdata = fill_pair;
                    n_a       = AW'(fill_pair.low);
                    n_b       = fill_b_next;
                    n_pos     = r_pos + LW'(1);
                end else if (r_init) begin
                    n_state = S_ZERO;
                end else if (r_scan && r_has_more) begin
                    n_pos   = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    n_pos   = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_ZERO: begin
                if (r_pos < LW'(MAX_LENGTH)) begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                    n_pos     = r_pos + LW'(1);
                end else begin
                    n_init  = 1'b0;
                    n_pos   = '0;
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_pos != '0 && rd_pair == r_prev) begin
                    // Equal neighbors: advance again from the later one.
                    n_t     = r_pos;
                    n_state = S_CARRY_RD;
                end else begin
                    n_prev = rd_pair;
                    if (len_last) begin
                        n_pos   = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_pos   = r_pos + LW'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_state     = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (out_accept) begin
                    n_out_valid = 1'b0;
                    if (len_last) begin
                        n_pos   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + LW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_REFILL;
            r_pos            <= '0;
            r_t              <= '0;
            r_a              <= AW'(0);
            r_b              <= AW'(1);
            r_has_more       <= 1'b1;
            r_scan           <= 1'b0;
            r_init           <= 1'b1;
            r_out_valid      <= 1'b0;
            r_wire_count     <= CFG_W'(RESET_WIRES);
            r_network_length <= CFG_W'(RESET_LENGTH);
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_t         <= n_t;
            r_a         <= n_a;
            r_b         <= n_b;
            r_has_more  <= n_has_more;
            r_scan      <= n_scan;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WIRE_COUNT:     r_wire_count     <= i_cfg_data;
                    REG_NETWORK_LENGTH: r_network_length <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload and scratch pairs need no reset.
    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_prev  <= n_prev;
        if (r_state == S_EMIT_LD) begin
            r_out_pos    <= FIELD_W'(r_pos);
            r_out_first  <= FIELD_W'(rd_pair.low);
            r_out_second <= FIELD_W'(rd_pair.high);
            r_out_more   <= r_has_more;
            r_out_last   <= len_last;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_position       = r_out_pos;
    assign o_first_wire     = r_out_first;
    assign o_second_wire    = r_out_second;
    assign o_more_available = r_out_more;
    assign o_last_pair      = r_out_last;

    // A result item is only ever offered while the emit step waits for it.
    a_valid_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_EMIT_HOLD)
        else $error("result offered outside the emit hold step");

    // While idle the store is written only by an accepted load item.
    a_idle_write_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_IDLE) |-> (in_accept && i_func == FUNC_LOAD))
        else $error("store written while idle without a load item");

    // Taking the last pair of a network returns the block to idle.
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && o_last_pair) |=> (r_state == S_IDLE && !o_valid))
        else $error("block still busy after the final pair was taken");

    // The duplicate scan never walks past the end of the network.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN_CMP |-> r_pos < len_eff)
        else $error("duplicate scan ran past the network length");

endmodule

// ----- tb/cse_result_checker.sv -----
// ----------------------------------------------------------------------------
// cse_result_checker
// Watches the configuration, input and result channels of the comparator
// sequence enumerator, keeps its own copy of the pair sequence, predicts
// every emitted pair and compares each result item with the oldest one.
// ----------------------------------------------------------------------------
module cse_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cse_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [cse_pkg::FUNC_W-1:0]    i_func,
    input  logic [cse_pkg::FIELD_W-1:0]   i_load_position,
    input  logic [cse_pkg::FIELD_W-1:0]   i_load_first,
    input  logic [cse_pkg::FIELD_W-1:0]   i_load_second,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [cse_pkg::FIELD_W-1:0]   o_position,
    input  logic [cse_pkg::FIELD_W-1:0]   o_first_wire,
    input  logic [cse_pkg::FIELD_W-1:0]   o_second_wire,
    input  logic                          o_more_available,
    input  logic                          o_last_pair,
    output int                            fail_count,
    output int                            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    localparam int SEQ_DEPTH = DEF_MAX_LENGTH;
    localparam int WIRE_MAX  = DEF_MAX_WIRES;

    typedef struct packed {
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] first_wire;
        logic [FIELD_W-1:0] second_wire;
        logic               more_available;
        logic               last_pair;
    } t_pair_result;

    logic [FIELD_W-1:0] seq_lo [SEQ_DEPTH];
    logic [FIELD_W-1:0] seq_hi [SEQ_DEPTH];
    bit                 more_left;
    logic [CFG_W-1:0]   wire_cfg;
    logic [CFG_W-1:0]   length_cfg;
    t_pair_result       expected_pairs [$];
    int                 mismatches = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic int wires_in_use();
        int n;
        n = wire_cfg;
        if (n < 2) n = 2;
        if (n > WIRE_MAX) n = WIRE_MAX;
        return n;
    endfunction

    function automatic int length_in_use();
        int l;
        l = length_cfg;
        if (l < 1) l = 1;
        if (l > SEQ_DEPTH) l = SEQ_DEPTH;
        return l;
    endfunction

    // Steps one pair without carrying; true when it wrapped back to (0,1).
    function automatic bit step_pair(int i, int n);
        int a;
        int b;
        bit wrapped;
        a = seq_lo[i];
        b = int'(seq_hi[i]) + 1;
        wrapped = 1'b0;
        if (b >= n) begin
            a = a + 1;
            b = a + 1;
        end
        if (b >= n) begin
            a = 0;
            b = 1;
            wrapped = 1'b1;
        end
        seq_lo[i] = a[FIELD_W-1:0];
        seq_hi[i] = b[FIELD_W-1:0];
        return wrapped;
    endfunction

    function automatic void carry_from(int start, int n);
        int pos;
        pos = start;
        forever begin
            if (!step_pair(pos, n)) return;
            if (pos == 0) break;
            pos--;
        end
        more_left = 1'b0;
    endfunction

    function automatic void refill_from(int s, int n, int l);
        int a;
        int b;
        a = 0;
        b = 1;
        if (s >= 1 && s <= l && seq_lo[s-1] == 0 && seq_hi[s-1] == 1
            && n > SMALL_WIRE_LIMIT)
            b = 2;
        for (int i = s; i < l; i++) begin
            if (b == n) begin
                a = a + 1;
                b = a + 1;
            end
            if (b >= n) begin
                a = 0;
                b = 1;
            end
            seq_lo[i] = a[FIELD_W-1:0];
            seq_hi[i] = b[FIELD_W-1:0];
            b = b + 1;
        end
    endfunction

    function automatic void queue_network(int l);
        t_pair_result r;
        for (int i = 0; i < l; i++) begin
            r.position       = i[FIELD_W-1:0];
            r.first_wire     = seq_lo[i];
            r.second_wire    = seq_hi[i];
            r.more_available = more_left;
            r.last_pair      = (i + 1 == l);
            expected_pairs.push_back(r);
        end
    endfunction

    function automatic void clear_state();
        wire_cfg   = CFG_W'(RESET_WIRES);
        length_cfg = CFG_W'(RESET_LENGTH);
        for (int i = 0; i < SEQ_DEPTH; i++) begin
            seq_lo[i] = '0;
            seq_hi[i] = '0;
        end
        refill_from(0, wires_in_use(), length_in_use());
        more_left = 1'b1;
        expected_pairs.delete();
    endfunction

    // Applies one accepted item to the pair sequence and queues the pairs
    // that a restart or an advance emits.
    function automatic void apply_operation(logic [FUNC_W-1:0] func,
                                            logic [FIELD_W-1:0] pos,
                                            logic [FIELD_W-1:0] first,
                                            logic [FIELD_W-1:0] second);
        int n;
        int l;
        int t;
        bit again;
        n = wires_in_use();
        l = length_in_use();
        case (func)
            FUNC_RESTART: begin
                refill_from(0, n, l);
                more_left = 1'b1;
                queue_network(l);
            end
            FUNC_ADVANCE: begin
                t = l - 1;
                do begin
                    carry_from(t, n);
                    refill_from(t + 1, n, l);
                    again = 1'b0;
                    for (int i = 0; i + 1 < l; i++) begin
                        if (seq_lo[i] == seq_lo[i+1] && seq_hi[i] == seq_hi[i+1]) begin
                            t = i + 1;
                            again = 1'b1;
                            break;
                        end
                    end
                end while (again && more_left);
                queue_network(l);
            end
            FUNC_LOAD: begin
                seq_lo[pos] = first;
                seq_hi[pos] = second;
                more_left = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pair_result want;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_pairs.size() == 0) begin
                    $error("result item with no expectation: position %0d pair (%0d,%0d)",
                           o_position, o_first_wire, o_second_wire);
                    mismatches++;
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("position", want.position, o_position);
                    check_field("first_wire", want.first_wire, o_first_wire);
                    check_field("second_wire", want.second_wire, o_second_wire);
                    check_field("more_available", want.more_available, o_more_available);
                    check_field("last_pair", want.last_pair, o_last_pair);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_WIRE_COUNT) wire_cfg = i_cfg_data;
                else if (i_cfg_index == REG_NETWORK_LENGTH) length_cfg = i_cfg_data;
            end
            if (i_valid && !o_stall)
                apply_operation(i_func, i_load_position, i_load_first, i_load_second);
        end
        fail_count    <= mismatches;
        pending_count <= expected_pairs.size();
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench top for the comparator sequence enumerator: drives directed and
// random restart, advance and load items over a range of wire counts and
// network lengths, with random idling on both channels, and reports the
// verdict from the result checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    // The func field has one code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Cycles without any handshake before the run is declared hung. An
    // advance with repeated duplicate scans and the long receiver hold-off
    // both stay far below this.
    localparam int WATCHDOG_LIMIT = 50000;
    // Length of the receiver hold-off that makes the block back up.
    localparam int HOLD_CYCLES    = 300;
    // Quiet cycles before a register write and at the end of the run.
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_PHASES  = 12;
    localparam int ITEMS_PER_PHASE = 27;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [FIELD_W-1:0]   i_load_position = '0;
    logic [FIELD_W-1:0]   i_load_first = '0;
    logic [FIELD_W-1:0]   i_load_second = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [FIELD_W-1:0]   o_position;
    logic [FIELD_W-1:0]   o_first_wire;
    logic [FIELD_W-1:0]   o_second_wire;
    logic                 o_more_available;
    logic                 o_last_pair;

    int fail_count;
    int pending_count;

    // Idling switch shared by both sides, and the one-shot hold-off request.
    bit idle_en    = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;

    // Effective wire count of the current setting, used to aim loads at
    // pairs that are in range.
    int cur_wires = RESET_WIRES;

    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    comparator_sequence_enumerator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_load_position  (i_load_position),
        .i_load_first     (i_load_first),
        .i_load_second    (i_load_second),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_position       (o_position),
        .o_first_wire     (o_first_wire),
        .o_second_wire    (o_second_wire),
        .o_more_available (o_more_available),
        .o_last_pair      (o_last_pair)
    );

    cse_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_load_position  (i_load_position),
        .i_load_first     (i_load_first),
        .i_load_second    (i_load_second),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_position       (o_position),
        .o_first_wire     (o_first_wire),
        .o_second_wire    (o_second_wire),
        .o_more_available (o_more_available),
        .o_last_pair      (o_last_pair),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    // The watchdog restarts its count on every handshake of any channel. If
    // the block hangs, the run ends here with the failure verdict.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[comparator_sequence_enumerator_top] ERROR");
            $finish;
        end
    end

    // The receiver side. Each pass through the loop waits for an edge before
    // each drive of i_stall, so the stall line never gets two assignments in
    // one time step. The single long hold-off is counted here, while the
    // sender keeps offering items and the block backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offers one item and returns at the edge where it is accepted. The
    // valid line is left high, so a following item without a gap simply
    // replaces the payload in the same step.
    task automatic offer_item(input logic [FUNC_W-1:0]  func,
                              input logic [FIELD_W-1:0] pos,
                              input logic [FIELD_W-1:0] first,
                              input logic [FIELD_W-1:0] second);
        if (idle_en && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_func          <= func;
        i_load_position <= pos;
        i_load_first    <= first;
        i_load_second   <= second;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drops valid and waits until every expected result item has arrived.
    // A load gives no result, so the task also waits out the settle time to
    // let the block finish it before anything else changes.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0]     data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Changes both registers while the block is idle.
    task automatic configure(input int wires, input int length);
        settle();
        write_register(REG_WIRE_COUNT, CFG_W'(wires));
        write_register(REG_NETWORK_LENGTH, CFG_W'(length));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cur_wires = (wires < 2) ? 2 : (wires > DEF_MAX_WIRES) ? DEF_MAX_WIRES : wires;
    endtask

    // Random items are mostly advances, so that enumeration runs deep into
    // each setting, mixed with restarts, loads of in-range and arbitrary
    // pairs, and the odd ignored code.
    task automatic random_items(input int count);
        int pick;
        int lo;
        int hi;
        logic [FUNC_W-1:0] func;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) func = FUNC_ADVANCE;
            else if (pick < 80) func = FUNC_RESTART;
            else if (pick < 96) func = FUNC_LOAD;
            else func = FUNC_UNUSED;
            if ($urandom_range(0, 1) == 0) begin
                lo = $urandom_range(0, cur_wires - 2);
                hi = $urandom_range(lo + 1, cur_wires - 1);
            end else begin
                lo = $urandom_range(0, 15);
                hi = $urandom_range(0, 15);
            end
            offer_item(func, FIELD_W'($urandom_range(0, 15)), FIELD_W'(lo), FIELD_W'(hi));
        end
    endtask

    initial begin
        int wires;
        int length;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block writes its initial pattern after reset; items simply
        // wait on o_stall, but the register writes later wait for idle.
        @(posedge i_clk);

        // Reset setting of four wires and four pairs. The first advance
        // starts from the pattern written after reset.
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_RESTART, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        // A load beyond the network length, and an out-of-range pair in the
        // first position ahead of the next advance.
        offer_item(FUNC_LOAD, 4'd15, 4'd15, 4'd15);
        offer_item(FUNC_LOAD, 4'd0, 4'd15, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        // Two equal neighboring pairs force the duplicate repeat.
        offer_item(FUNC_LOAD, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_LOAD, 4'd1, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        // The ignored code must leave no trace.
        offer_item(FUNC_UNUSED, 4'd15, 4'd15, 4'd15);
        offer_item(FUNC_UNUSED, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_RESTART, 4'd0, 4'd0, 4'd0);

        // Two wires and one pair: the first advance runs past the final
        // network, the next one advances while finished, and a load brings
        // the flag back.
        configure(2, 1);
        offer_item(FUNC_RESTART, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_LOAD, 4'd0, 4'd0, 4'd1);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);

        // Register values below and above the meaningful range saturate.
        configure(0, 0);
        offer_item(FUNC_RESTART, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);

        configure(31, 31);
        offer_item(FUNC_RESTART, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);
        offer_item(FUNC_ADVANCE, 4'd0, 4'd0, 4'd0);

        // Random phases. The first one uses the largest exact setting and
        // carries the long receiver hold-off; the last one runs without
        // idling on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                wires  = DEF_MAX_WIRES;
                length = DEF_MAX_LENGTH;
            end else begin
                wires  = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 6) : $urandom_range(0, 31);
                length = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 31);
            end
            configure(wires, length);
            if (phase == RANDOM_PHASES - 1) idle_en = 1'b0;
            else idle_en = ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                idle_en  = 1'b1;
                hold_req = 1'b1;
            end
            offer_item(FUNC_RESTART, FIELD_W'($urandom_range(0, 15)),
                       FIELD_W'($urandom_range(0, 15)), FIELD_W'($urandom_range(0, 15)));
            random_items(ITEMS_PER_PHASE);
        end

        // Wait for the last results, then give the block time to show any
        // stray result item before the verdict.
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[comparator_sequence_enumerator_top] OK");
        end else begin
            $display("[comparator_sequence_enumerator_top] ERROR");
        end
        $finish;
    end

endmodule
